[src/krs_pkg.sv]
// Shared types and constants for the keyed record stack.
// Holds field widths, command and status codes, controller states and record/result structs.
// No dependencies; every other file of the block imports this package.
package krs_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int CMD_W     = 3;
  localparam int KEY_W     = 48;
  localparam int PAY_W     = 32;
  localparam int STAT_W    = 2;
  localparam int COUNT_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_SEARCH  = 3'd2,
    CMD_DELETE  = 3'd3,
    CMD_REVERSE = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SRCH,
    S_DEL,
    S_REV_A,
    S_REV_B,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } record_t;

  typedef struct packed {
    status_e            status;
    logic               found;
    logic [KEY_W-1:0]   key;
    logic [PAY_W-1:0]   payload;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

[src/krs_if.sv]
// Valid/ready channel interfaces for the keyed record stack command and result words.
// Depends on krs_pkg for the field widths.
interface krs_in_if import krs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [KEY_W-1:0]   record_key;
  logic [PAY_W-1:0]   record_payload;

  modport source (output valid, command, record_key, record_payload, input ready);
  modport sink   (input valid, command, record_key, record_payload, output ready);
endinterface

interface krs_out_if import krs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic               found;
  logic [KEY_W-1:0]   out_key;
  logic [PAY_W-1:0]   out_payload;
  logic [COUNT_W-1:0] count;

  modport source (output valid, status, found, out_key, out_payload, count, input ready);
  modport sink   (input valid, status, found, out_key, out_payload, count, output ready);
endinterface

[src/krs_mem.sv]
// Record memory of the keyed record stack: one write port, two registered read ports.
// Depends on krs_pkg for the record type.
module krs_mem import krs_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  record_t       wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output record_t       rdata_a,
  output record_t       rdata_b
);

  record_t mem [DEPTH];
  record_t rd_a_r;
  record_t rd_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_a_r <= mem[raddr_a];
      rd_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

[src/krs_ctrl.sv]
// Command sequencer of the keyed record stack: decodes a word and walks the record memory.
// Depends on krs_pkg; drives krs_mem and hands a result_t to the output register.
module krs_ctrl import krs_pkg::*; #(
  parameter int DEPTH   = DEPTH_DEF,
  localparam int AW     = $clog2(DEPTH),
  localparam int CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic [KEY_W-1:0] in_key,
  input  logic [PAY_W-1:0] in_pay,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output record_t          mem_wdata,
  output logic             mem_re,
  output logic [AW-1:0]    mem_raddr_a,
  output logic [AW-1:0]    mem_raddr_b,
  input  record_t          mem_rdata_a,
  input  record_t          mem_rdata_b,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res
);

  state_e           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] wr_r, wr_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [AW-1:0]    hi_r, hi_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  result_t          res_r, res_nxt;

  logic [AW:0]      idx_inc;
  logic [AW:0]      idx_inc2;
  logic             scan_last;
  logic [AW-1:0]    top_addr;
  logic [CNT_W-1:0] keep_cnt;

  assign idx_inc   = {1'b0, idx_r} + 1'b1;
  assign idx_inc2  = {1'b0, idx_r} + 2'd2;
  assign scan_last = (idx_inc == (AW+1)'(cnt_r));
  assign top_addr  = AW'(cnt_r - 1'b1);
  assign keep_cnt  = (mem_rdata_a.key != key_r) ? wr_r + 1'b1 : wr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_r  <= wr_nxt;
    idx_r <= idx_nxt;
    hi_r  <= hi_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    wr_nxt      = wr_r;
    idx_nxt     = idx_r;
    hi_nxt      = hi_r;
    key_nxt     = key_r;
    res_nxt     = res_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = mem_rdata_a;
    mem_re      = 1'b0;
    mem_raddr_a = '0;
    mem_raddr_b = '0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          key_nxt         = in_key;
          idx_nxt         = '0;
          wr_nxt          = '0;
          res_nxt.status  = ST_OK;
          res_nxt.found   = 1'b0;
          res_nxt.key     = '0;
          res_nxt.payload = '0;
          state_nxt       = S_FIN;
          unique case (cmd_e'(in_cmd))
            CMD_PUSH: begin
              if (cnt_r == CNT_W'(DEPTH)) begin
                res_nxt.status = ST_FULL;
              end else begin
                mem_we            = 1'b1;
                mem_waddr         = AW'(cnt_r);
                mem_wdata.key     = in_key;
                mem_wdata.payload = in_pay;
                cnt_nxt           = cnt_r + 1'b1;
              end
            end
            CMD_POP: begin
              if (cnt_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                mem_re      = 1'b1;
                mem_raddr_a = top_addr;
                cnt_nxt     = cnt_r - 1'b1;
                state_nxt   = S_POP;
              end
            end
            CMD_SEARCH, CMD_DELETE: begin
              if (cnt_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                state_nxt = (cmd_e'(in_cmd) == CMD_SEARCH) ? S_SRCH : S_DEL;
              end
            end
            CMD_REVERSE: begin
              if (cnt_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else if (cnt_r != CNT_W'(1)) begin
                mem_re      = 1'b1;
                mem_raddr_b = top_addr;
                hi_nxt      = top_addr;
                state_nxt   = S_REV_A;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_POP: begin
        res_nxt.key     = mem_rdata_a.key;
        res_nxt.payload = mem_rdata_a.payload;
        state_nxt       = S_FIN;
      end

      // Data of entry idx_r is on the read port; the first match from the bottom wins.
      S_SRCH: begin
        if (mem_rdata_a.key == key_r) begin
          res_nxt.found   = 1'b1;
          res_nxt.key     = mem_rdata_a.key;
          res_nxt.payload = mem_rdata_a.payload;
          state_nxt       = S_FIN;
        end else if (scan_last) begin
          res_nxt.status = ST_NOTFOUND;
          state_nxt      = S_FIN;
        end else begin
          mem_re      = 1'b1;
          mem_raddr_a = idx_inc[AW-1:0];
          idx_nxt     = idx_inc[AW-1:0];
        end
      end

      // Survivors are compacted downward; the write slot never passes the read pointer.
      S_DEL: begin
        if (mem_rdata_a.key != key_r) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(wr_r);
          mem_wdata = mem_rdata_a;
        end
        wr_nxt = keep_cnt;
        if (scan_last) begin
          cnt_nxt        = keep_cnt;
          res_nxt.status = (keep_cnt == cnt_r) ? ST_NOTFOUND : ST_OK;
          state_nxt      = S_FIN;
        end else begin
          mem_re      = 1'b1;
          mem_raddr_a = idx_inc[AW-1:0];
          idx_nxt     = idx_inc[AW-1:0];
        end
      end

      S_REV_A: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata_b;
        state_nxt = S_REV_B;
      end

      S_REV_B: begin
        mem_we    = 1'b1;
        mem_waddr = hi_r;
        mem_wdata = mem_rdata_a;
        if (idx_inc2 < {1'b0, hi_r}) begin
          mem_re      = 1'b1;
          mem_raddr_a = idx_inc[AW-1:0];
          mem_raddr_b = hi_r - 1'b1;
          idx_nxt     = idx_inc[AW-1:0];
          hi_nxt      = hi_r - 1'b1;
          state_nxt   = S_REV_A;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res       = res_r;
    res.count = COUNT_W'(cnt_r);
  end

endmodule

[src/keyed_record_stack_core.sv]
// Top level of the keyed record stack: command channel in, result channel out.
// Depends on krs_pkg, krs_if, krs_mem and krs_ctrl.
//
//   channel   direction  word contents
//   in_chan   in         command, record_key, record_payload
//   out_chan  out        status, found, out_key, out_payload, count
//
// One command word is in work at a time, from acceptance to a result in the output
// register. Search and delete read one entry per cycle from the record memory, so delete
// and a missed search read all n entries held; a search that hits entry i stops there.
// Reverse swaps one pair of entries at a time through the single write port.
// Reset clears the entry count and the control state; the memory is never cleared, since
// only entries below the count are ever read. A stalled result waits in the output
// register while the next command is already taken and worked on.
module keyed_record_stack_core import krs_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  krs_in_if.sink     in_chan,
  krs_out_if.source  out_chan
);

  localparam int AW = $clog2(DEPTH);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  record_t       mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr_a;
  logic [AW-1:0] mem_raddr_b;
  record_t       mem_rdata_a;
  record_t       mem_rdata_b;

  logic          res_valid;
  logic          res_ready;
  result_t       res;

  logic          out_valid_r;
  result_t       out_word_r;

  krs_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  krs_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .in_cmd      (in_chan.command),
    .in_key      (in_chan.record_key),
    .in_pay      (in_chan.record_payload),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_a (mem_rdata_a),
    .mem_rdata_b (mem_rdata_b),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // The output register takes a new result when it is empty or being drained this cycle.
  assign res_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word_r <= res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_word_r.status;
  assign out_chan.found       = out_word_r.found;
  assign out_chan.out_key     = out_word_r.key;
  assign out_chan.out_payload = out_word_r.payload;
  assign out_chan.count       = out_word_r.count;

endmodule

[bench/keyed_record_stack_core_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for keyed_record_stack_core: sends command words and predicts every result word.
// Depends on krs_pkg, the krs_in_if and krs_out_if channel interfaces and the core itself.
module keyed_record_stack_core_test;
  import krs_pkg::*;

  localparam int STACK_DEPTH   = DEPTH_DEF;
  localparam int CLK_HALF      = 6;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_WORDS  = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int POOL_SIZE     = 6;

  // Command codes 5 to 7 have no meaning; the core must answer them with OK and no change.
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
  localparam logic [KEY_W-1:0] KEY_ONES = '1;
  localparam logic [PAY_W-1:0] PAY_ONES = '1;

  logic clk;
  logic rst_n;

  krs_in_if  in_chan ();
  krs_out_if out_chan ();

  keyed_record_stack_core #(.DEPTH(STACK_DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Our own copy of the stack. Entry 0 is the bottom, entry held_count-1 the top.
  logic [KEY_W-1:0] held_keys     [STACK_DEPTH];
  logic [PAY_W-1:0] held_payloads [STACK_DEPTH];
  int unsigned      held_count = 0;

  // Result words we expect, oldest first.
  result_t          pending_replies [$];

  int unsigned      error_count = 0;
  int unsigned      cycle_count = 0;

  // Sender burst state; gaps can be switched off for stretches of back-to-back words.
  int unsigned      burst_left = 0;
  bit               gaps_enabled = 1'b1;

  // Each increment asks the receiver process for one long hold-off.
  int unsigned      holds_requested = 0;

  // A small set of keys that most words draw from, so that searches and deletes hit often.
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Applies one command to the local stack and returns the result word it must produce.
  // Search walks up from the bottom, so the deepest match wins. Delete compacts the
  // survivors downward and keeps their order.
  function automatic result_t apply_stack_command(input logic [CMD_W-1:0] cmd,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [PAY_W-1:0] payload);
    result_t          reply;
    int unsigned      idx;
    int unsigned      kept;
    logic [KEY_W-1:0] swap_key;
    logic [PAY_W-1:0] swap_pay;
    reply = '0;
    reply.status = ST_OK;
    case (cmd)
      CMD_PUSH: begin
        if (held_count == STACK_DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          held_keys[held_count]     = key;
          held_payloads[held_count] = payload;
          held_count++;
        end
      end
      CMD_POP: begin
        if (held_count == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          held_count--;
          reply.key     = held_keys[held_count];
          reply.payload = held_payloads[held_count];
        end
      end
      CMD_SEARCH: begin
        if (held_count == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          reply.status = ST_NOTFOUND;
          for (idx = 0; idx < held_count; idx++) begin
            if (held_keys[idx] == key) begin
              reply.status  = ST_OK;
              reply.found   = 1'b1;
              reply.key     = held_keys[idx];
              reply.payload = held_payloads[idx];
              break;
            end
          end
        end
      end
      CMD_DELETE: begin
        if (held_count == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          kept = 0;
          for (idx = 0; idx < held_count; idx++) begin
            if (held_keys[idx] != key) begin
              held_keys[kept]     = held_keys[idx];
              held_payloads[kept] = held_payloads[idx];
              kept++;
            end
          end
          reply.status = (kept == held_count) ? ST_NOTFOUND : ST_OK;
          held_count = kept;
        end
      end
      CMD_REVERSE: begin
        if (held_count == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          for (idx = 0; idx < held_count / 2; idx++) begin
            swap_key = held_keys[idx];
            swap_pay = held_payloads[idx];
            held_keys[idx]     = held_keys[held_count - 1 - idx];
            held_payloads[idx] = held_payloads[held_count - 1 - idx];
            held_keys[held_count - 1 - idx]     = swap_key;
            held_payloads[held_count - 1 - idx] = swap_pay;
          end
        end
      end
      default: begin
        // Spare codes leave everything alone.
      end
    endcase
    reply.count = COUNT_W'(held_count);
    return reply;
  endfunction

  // Offers one command word and returns once the core has taken it. A new burst may start
  // with an idle gap; within a burst valid stays high from word to word.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                           input logic [PAY_W-1:0] payload);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 20);
      if (gaps_enabled && gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_chan.valid          <= 1'b1;
    in_chan.command        <= cmd;
    in_chan.record_key     <= key;
    in_chan.record_payload <= payload;
    // Values seen right after the edge are the ones the core sampled at it.
    do @(posedge clk); while (!in_chan.ready);
    pending_replies.push_back(apply_stack_command(cmd, key, payload));
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    logic [63:0] wide;
    if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    wide = {$urandom(), $urandom()};
    return wide[KEY_W-1:0];
  endfunction

  // Filling favors pushes, draining favors pops; every command keeps some share.
  function automatic logic [CMD_W-1:0] pick_command(input bit filling);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < (filling ? 50 : 15)) return CMD_PUSH;
    if (roll < (filling ? 60 : 55)) return CMD_POP;
    if (roll < (filling ? 75 : 70)) return CMD_SEARCH;
    if (roll < (filling ? 85 : 82)) return CMD_DELETE;
    if (roll < (filling ? 95 : 94)) return CMD_REVERSE;
    return CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
  endfunction

  // Receiver: ready follows a mode that is drawn anew after each stretch of random length,
  // from always ready to mostly stalled. A requested hold-off overrides the mode for LONG_HOLD.
  initial begin
    int unsigned holds_served;
    int unsigned hold_left;
    int unsigned pattern_left;
    int unsigned mode;
    holds_served = 0;
    hold_left    = 0;
    pattern_left = 0;
    mode         = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_requested) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (pattern_left == 0) begin
        mode = $urandom_range(0, 3);
        pattern_left = $urandom_range(32, 256);
      end
      pattern_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_chan.ready <= 1'b1;
          1: out_chan.ready <= 1'($urandom_range(0, 1));
          2: out_chan.ready <= ($urandom_range(0, 3) == 0);
          default: out_chan.ready <= (pattern_left % 3 == 0);
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [KEY_W-1:0] want,
                             input logic [KEY_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Every result word taken by the receiver is held against the oldest expectation.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: result word with none expected, status %0d count %0d", $time,
                 out_chan.status, out_chan.count);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        check_field("status", KEY_W'(want.status), KEY_W'(out_chan.status));
        check_field("found", KEY_W'(want.found), KEY_W'(out_chan.found));
        check_field("out_key", want.key, out_chan.out_key);
        check_field("out_payload", KEY_W'(want.payload), KEY_W'(out_chan.out_payload));
        check_field("count", KEY_W'(want.count), KEY_W'(out_chan.count));
      end
    end
  end

  // Every command but push on an empty stack, plus the spare codes at both ends of their range.
  task automatic test_empty_stack();
    send_word(CMD_POP, '0, '0);
    send_word(CMD_SEARCH, '0, '0);
    send_word(CMD_DELETE, KEY_ONES, PAY_ONES);
    send_word(CMD_REVERSE, '0, '0);
    send_word(CMD_SPARE_FIRST, KEY_ONES, PAY_ONES);
    send_word(CMD_SPARE_LAST, '0, '0);
  endtask

  // Duplicate keys: search must return the deepest copy, reverse must move it to the top,
  // delete must drop every copy, and a missing key must leave the stack alone.
  task automatic test_record_ops();
    send_word(CMD_PUSH, key_pool[2], '0);
    send_word(CMD_PUSH, KEY_ONES, PAY_ONES);
    send_word(CMD_PUSH, key_pool[2], 32'hA5A5_5A5A);
    send_word(CMD_SEARCH, key_pool[2], '0);
    send_word(CMD_SEARCH, key_pool[3], '0);
    send_word(CMD_REVERSE, '0, '0);
    send_word(CMD_POP, '0, '0);
    send_word(CMD_DELETE, key_pool[2], '0);
    send_word(CMD_DELETE, key_pool[3], '0);
  endtask

  // The receiver holds off while pushes come back to back, so the core has to stall its
  // input. The stack fills with records whose key and payload alternate between all zeros
  // and all ones, and then refuses one more push.
  task automatic test_full_under_backpressure();
    gaps_enabled = 1'b0;
    holds_requested <= holds_requested + 1;
    while (held_count < STACK_DEPTH) begin
      send_word(CMD_PUSH, (held_count % 2 == 0) ? '0 : KEY_ONES,
                (held_count % 2 == 0) ? PAY_ONES : '0);
    end
    send_word(CMD_PUSH, KEY_ONES, PAY_ONES);
    send_word(CMD_SEARCH, '0, '0);
    gaps_enabled = 1'b1;
  endtask

  // Long random traffic that swings the stack between empty and full. Now and then the
  // sender runs without gaps, and the receiver is asked for another long hold-off.
  task automatic test_random_traffic();
    bit          filling;
    int unsigned n;
    filling = 1'b1;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 200 == 0) gaps_enabled = ($urandom_range(0, 3) != 0);
      if (n % 500 == 250) holds_requested <= holds_requested + 1;
      if (held_count == 0) filling = 1'b1;
      else if (held_count == STACK_DEPTH && $urandom_range(0, 2) == 0) filling = 1'b0;
      else if ($urandom_range(0, 49) == 0) filling = !filling;
      send_word(pick_command(filling), pick_key(), $urandom());
    end
  endtask

  initial begin
    int unsigned idx;
    rst_n                  <= 1'b0;
    in_chan.valid          <= 1'b0;
    in_chan.command        <= '0;
    in_chan.record_key     <= '0;
    in_chan.record_payload <= '0;
    key_pool[0] = '0;
    key_pool[1] = KEY_ONES;
    key_pool[2] = 48'h8000_0000_0000;
    key_pool[3] = 48'h0000_0000_0001;
    for (idx = 4; idx < POOL_SIZE; idx++) key_pool[idx] = KEY_W'({$urandom(), $urandom()});
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_stack();
    test_record_ops();
    test_full_under_backpressure();
    test_random_traffic();

    in_chan.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    // Extra cycles catch any stray word that shows up after the last expected one.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
